/* rtl/mwm_pkg.sv */
package mwm_pkg;

    // Field widths
    localparam int CMD_W      = 15;
    localparam int LIM_W      = 14;
    localparam int CEIL_W     = 15;
    localparam int SUM_W      = 17;
    localparam int MAG_W      = 16;
    localparam int WHEEL_W    = 16;
    localparam int PROD_W     = MAG_W + CEIL_W;
    localparam int NUM_CMDS   = 3;
    localparam int NUM_WHEELS = 4;

    // Stream widths, whole bytes
    localparam int IN_TDATA_W  = ((NUM_CMDS * CMD_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = NUM_WHEELS * WHEEL_W;

    // Pipeline shape: clamp, mix, magnitude, peak, multiply, one stage per
    // quotient bit, then the output register.
    localparam int DIV_STEPS    = 15;
    localparam int FRONT_STAGES = 5;
    localparam int NUM_STAGES   = FRONT_STAGES + DIV_STEPS + 1;

    // Register reset values
    localparam logic [LIM_W-1:0]  LIMIT_RESET   = 14'h3FFF;
    localparam logic [CEIL_W-1:0] CEILING_RESET = 15'd3500;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LIMIT_FORWARD  = 2'd0,
        REG_LIMIT_SIDEWAYS = 2'd1,
        REG_LIMIT_ROTATION = 2'd2,
        REG_WHEEL_CEILING  = 2'd3
    } cfg_reg_t;

    typedef logic signed [CMD_W-1:0]   cmd_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic        [MAG_W-1:0]   mag_t;
    typedef logic        [PROD_W-1:0]  prod_t;
    typedef logic        [DIV_STEPS-1:0] quo_t;
    typedef logic signed [WHEEL_W-1:0] wheel_t;

    // Symmetric clamp of a command to +/- lim.
    function automatic cmd_t clamp_cmd(input cmd_t v, input logic [LIM_W-1:0] lim);
        logic signed [CMD_W:0] ve;
        logic signed [CMD_W:0] le;
        logic signed [CMD_W:0] nle;
        cmd_t res;
        ve  = {v[CMD_W-1], v};
        le  = {2'b00, lim};
        nle = -le;
        if (ve > le) begin
            res = le[CMD_W-1:0];
        end else if (ve < nle) begin
            res = nle[CMD_W-1:0];
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

/* rtl/mecanum_wheel_mix_top.sv */
// Mecanum wheel mixer.
// Input stream (s_): one request holds the forward, sideways and rotation
// speed commands. Each command is clamped to its configured limit, the four
// wheel speeds are formed, and if the largest wheel magnitude exceeds the
// wheel ceiling all four are scaled by ceiling/peak, truncated toward zero.
// Output stream (m_): one request per input request, in order, with the
// four wheel speeds in tdata and the scaling flag in tuser.
// Configuration: cfg_wr_en writes cfg_wdata into the register cfg_index
// (0 forward limit, 1 sideways limit, 2 rotation limit, 3 wheel ceiling).
// Write registers only while no request is in flight.
// One request is accepted per cycle unless a stall at m_tready has filled
// the pipeline. The depth is set by the restoring divider, which resolves one
// quotient bit per stage over 15 stages for all four wheels.
// Each stage holds its contents while the stage after it is full and
// blocked, so a stall at m_tready fills empty stages first and only then
// drops s_tready; nothing is lost or repeated.
// Reset (aresetn low, synchronous) empties the pipeline and returns the
// limits to 16383 and the ceiling to 3500.
module mecanum_wheel_mix_top
    import mwm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CEIL_W-1:0]      cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // speed_forward, speed_sideways, speed_rotation, zero fill
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // wheel_front_a, wheel_front_b, wheel_rear_b, wheel_rear_a
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // was_scaled
    output logic [0:0]             m_tuser
);

    localparam int LAST = NUM_STAGES - 1;

    // Configuration registers
    logic [LIM_W-1:0]  limit_forward_reg;
    logic [LIM_W-1:0]  limit_sideways_reg;
    logic [LIM_W-1:0]  limit_rotation_reg;
    logic [CEIL_W-1:0] wheel_ceiling_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_forward_reg  <= LIMIT_RESET;
            limit_sideways_reg <= LIMIT_RESET;
            limit_rotation_reg <= LIMIT_RESET;
            wheel_ceiling_reg  <= CEILING_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_LIMIT_FORWARD:  limit_forward_reg  <= cfg_wdata[LIM_W-1:0];
                REG_LIMIT_SIDEWAYS: limit_sideways_reg <= cfg_wdata[LIM_W-1:0];
                REG_LIMIT_ROTATION: limit_rotation_reg <= cfg_wdata[LIM_W-1:0];
                REG_WHEEL_CEILING:  wheel_ceiling_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Per-stage valid bits and the load enables. A stage loads when it is
    // empty or when the stage after it loads.
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] adv;

    assign adv[LAST] = !vld_reg[LAST] || m_tready;
    for (genvar k = 0; k < LAST; k++) begin : g_adv
        assign adv[k] = !vld_reg[k] || adv[k+1];
    end

    always_comb begin
        vld_next[0] = adv[0] ? s_tvalid : vld_reg[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = adv[0];

    // Stage 1: clamp the three commands
    cmd_t vx_reg, vy_reg, w_reg;

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            vx_reg <= clamp_cmd(s_tdata[CMD_W-1:0], limit_forward_reg);
            vy_reg <= clamp_cmd(s_tdata[2*CMD_W-1:CMD_W], limit_sideways_reg);
            w_reg  <= clamp_cmd(s_tdata[3*CMD_W-1:2*CMD_W], limit_rotation_reg);
        end
    end

    // Stage 2: wheel mix
    sum_t sum1_reg [NUM_WHEELS];
    sum_t ex, ey, ew;

    assign ex = SUM_W'(vx_reg);
    assign ey = SUM_W'(vy_reg);
    assign ew = SUM_W'(w_reg);

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            sum1_reg[0] <= ex - ey + ew;
            sum1_reg[1] <= ex + ey + ew;
            sum1_reg[2] <= ey - ex + ew;
            sum1_reg[3] <= ew - ex - ey;
        end
    end

    // Stage 3: magnitudes and the first level of the maximum
    sum_t sum2_reg [NUM_WHEELS];
    mag_t mag2_reg [NUM_WHEELS];
    mag_t mag_next [NUM_WHEELS];
    mag_t pmax_a_reg, pmax_b_reg;
    sum_t neg_sum [NUM_WHEELS];

    always_comb begin
        for (int k = 0; k < NUM_WHEELS; k++) begin
            neg_sum[k]  = -sum1_reg[k];
            mag_next[k] = sum1_reg[k][SUM_W-1] ? neg_sum[k][MAG_W-1:0]
                                               : sum1_reg[k][MAG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            for (int k = 0; k < NUM_WHEELS; k++) begin
                sum2_reg[k] <= sum1_reg[k];
                mag2_reg[k] <= mag_next[k];
            end
            pmax_a_reg <= (mag_next[0] > mag_next[1]) ? mag_next[0] : mag_next[1];
            pmax_b_reg <= (mag_next[2] > mag_next[3]) ? mag_next[2] : mag_next[3];
        end
    end

    // Stage 4: peak magnitude and the scaling decision
    sum_t sum3_reg [NUM_WHEELS];
    mag_t mag3_reg [NUM_WHEELS];
    mag_t peak3_reg;
    logic scale3_reg;
    mag_t peak_next;

    assign peak_next = (pmax_a_reg > pmax_b_reg) ? pmax_a_reg : pmax_b_reg;

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            for (int k = 0; k < NUM_WHEELS; k++) begin
                sum3_reg[k] <= sum2_reg[k];
                mag3_reg[k] <= mag2_reg[k];
            end
            peak3_reg  <= peak_next;
            scale3_reg <= peak_next > MAG_W'(wheel_ceiling_reg);
        end
    end

    // Stage 5 and the divider: entry 0 holds |wheel| * ceiling, entry j has
    // quotient bits down to DIV_STEPS-j resolved.
    prod_t  rem_reg   [DIV_STEPS+1][NUM_WHEELS];
    quo_t   quo_reg   [DIV_STEPS+1][NUM_WHEELS];
    wheel_t raw_reg   [DIV_STEPS+1][NUM_WHEELS];
    logic   neg_reg   [DIV_STEPS+1][NUM_WHEELS];
    logic   scale_reg [DIV_STEPS+1];
    mag_t   dvsr_reg  [DIV_STEPS+1];

    always_ff @(posedge aclk) begin
        if (adv[FRONT_STAGES-1]) begin
            for (int k = 0; k < NUM_WHEELS; k++) begin
                rem_reg[0][k] <= prod_t'(mag3_reg[k]) * prod_t'(wheel_ceiling_reg);
                quo_reg[0][k] <= '0;
                raw_reg[0][k] <= sum3_reg[k][WHEEL_W-1:0];
                neg_reg[0][k] <= sum3_reg[k][SUM_W-1];
            end
            scale_reg[0] <= scale3_reg;
            dvsr_reg[0]  <= peak3_reg;
        end
    end

    // One restoring-division step per stage, shared divisor for all wheels
    for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
        localparam int QBIT = DIV_STEPS - j;
        localparam int IDX  = FRONT_STAGES - 1 + j;
        prod_t cand;

        assign cand = prod_t'(dvsr_reg[j-1]) << QBIT;

        always_ff @(posedge aclk) begin
            if (adv[IDX]) begin
                for (int k = 0; k < NUM_WHEELS; k++) begin
                    if (rem_reg[j-1][k] >= cand) begin
                        rem_reg[j][k] <= rem_reg[j-1][k] - cand;
                        quo_reg[j][k] <= quo_reg[j-1][k] | (quo_t'(1) << QBIT);
                    end else begin
                        rem_reg[j][k] <= rem_reg[j-1][k];
                        quo_reg[j][k] <= quo_reg[j-1][k];
                    end
                    raw_reg[j][k] <= raw_reg[j-1][k];
                    neg_reg[j][k] <= neg_reg[j-1][k];
                end
                scale_reg[j] <= scale_reg[j-1];
                dvsr_reg[j]  <= dvsr_reg[j-1];
            end
        end
    end

    // Output stage: restore the sign of the scaled speed or pass the raw one
    wheel_t wheel_next [NUM_WHEELS];
    wheel_t qpos [NUM_WHEELS];
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic [0:0]             m_tuser_reg;

    always_comb begin
        for (int k = 0; k < NUM_WHEELS; k++) begin
            qpos[k] = {1'b0, quo_reg[DIV_STEPS][k]};
            if (scale_reg[DIV_STEPS]) begin
                wheel_next[k] = neg_reg[DIV_STEPS][k] ? -qpos[k] : qpos[k];
            end else begin
                wheel_next[k] = raw_reg[DIV_STEPS][k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[LAST]) begin
            for (int k = 0; k < NUM_WHEELS; k++) begin
                m_tdata_reg[k*WHEEL_W +: WHEEL_W] <= wheel_next[k];
            end
            m_tuser_reg[0] <= scale_reg[DIV_STEPS];
        end
    end

    assign m_tvalid = vld_reg[LAST];
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* rtl/mwm_checker.sv */
module mwm_checker
    import mwm_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   cfg_wr_en,
    input logic [CFG_IDX_W-1:0]   cfg_index,
    input logic [CEIL_W-1:0]      cfg_wdata,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [IN_TDATA_W-1:0]  s_tdata,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic [0:0]             m_tuser
);

    localparam int CNT_W = $clog2(NUM_STAGES + 1);

    // Requests accepted but not yet delivered
    logic [CNT_W-1:0] open_reg;
    logic [CNT_W-1:0] open_next;
    logic s_acc, m_acc;

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    always_comb begin
        open_next = open_reg;
        if (s_acc && !m_acc) begin
            open_next = open_reg + CNT_W'(1);
        end else if (m_acc && !s_acc) begin
            open_next = open_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= '0;
        end else begin
            open_reg <= open_next;
        end
    end

    // Unscaled wheels keep the mix identity: front_a + rear_b == front_b + rear_a
    logic signed [WHEEL_W:0] diag_a, diag_b;

    assign diag_a = {m_tdata[WHEEL_W-1], m_tdata[WHEEL_W-1:0]}
                  + {m_tdata[3*WHEEL_W-1], m_tdata[3*WHEEL_W-1:2*WHEEL_W]};
    assign diag_b = {m_tdata[2*WHEEL_W-1], m_tdata[2*WHEEL_W-1:WHEEL_W]}
                  + {m_tdata[4*WHEEL_W-1], m_tdata[4*WHEEL_W-1:3*WHEEL_W]};

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result request dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result payload changed while stalled");

    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> open_reg != '0)
        else $error("result offered with no request outstanding");

    a_capacity: assert property (@(posedge aclk) disable iff (!aresetn)
        open_reg <= CNT_W'(NUM_STAGES))
        else $error("more requests in flight than pipeline stages");

    a_mix_identity: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> diag_a == diag_b)
        else $error("unscaled wheel speeds break the mix identity");

endmodule

bind mecanum_wheel_mix_top mwm_checker u_mwm_checker (.*);
